// ===== rtl/core/lock_gated_proportional_guidance_assert.svh =====
// assertion macros for the guidance core
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef LOCK_GATED_PROPORTIONAL_GUIDANCE_ASSERT_SVH
`define LOCK_GATED_PROPORTIONAL_GUIDANCE_ASSERT_SVH

// same-cycle implication
`define LGPG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LGPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lgpg_pkg.sv =====
// shared types and constants for the lock-gated guidance core
// no dependencies
package lgpg_pkg;

  localparam int unsigned GainW    = 16;
  localparam int unsigned LimitW   = 14;
  localparam int unsigned TimeoutW = 8;
  localparam int unsigned VelW     = 18;
  localparam int unsigned QuotW    = 17;

  localparam logic [LimitW-1:0] LimitMaxCms = 14'd10000;
  localparam logic [6:0]        CmToTenthMm = 7'd100;

  localparam logic [GainW-1:0]    GainAzReset   = 16'd100;
  localparam logic [GainW-1:0]    GainElReset   = 16'd100;
  localparam logic [LimitW-1:0]   LimitReset    = 14'd200;
  localparam logic [TimeoutW-1:0] TimeoutReset  = 8'd25;

  typedef enum logic [1:0] {
    MODE_WAITING = 2'd0,
    MODE_ACTIVE  = 2'd1,
    MODE_LOST    = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_VELOCITY = 2'd1,
    KIND_STOP     = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_GAIN_AZ = 2'd0,
    REG_GAIN_EL = 2'd1,
    REG_LIMIT   = 2'd2,
    REG_TIMEOUT = 2'd3
  } reg_e;

endpackage

// ===== rtl/core/lock_gated_proportional_guidance.sv =====
// lock-gated proportional guidance core: lock decode, engage/timeout control and a
// bit-serial velocity datapath (multiply, square, root, divide); uses lgpg_pkg
//
//  channel  | signals                              | moves
//  ---------+--------------------------------------+-------------------------------
//  input    | in_valid_i / in_ready_o              | one period word (frame or not)
//  output   | out_valid_o / out_ready_i            | one result word per input word
//  config   | psel/penable/pwrite/paddr/pwdata     | 32-bit register writes, reads
//
// a word that needs no velocity goes straight to the done state; with velocity it runs the
// one-bit-per-cycle multiply, square and divide loops, and the root and scale loops
// too when the speed cap applies. one word is in work at a time; a finished word waits
// in the output register while the next word is accepted. reset leaves guidance
// disengaged, mode waiting and the idle count saturated.
module lock_gated_proportional_guidance (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [15:0] status_word_i,
  input  logic signed [15:0] offset_azimuth_i,
  input  logic signed [15:0] offset_elevation_i,
  input  logic        vehicle_ready_i,
  input  logic        position_valid_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [17:0] velocity_x_mms_o,
  output logic signed [17:0] velocity_y_mms_o,
  output logic [1:0]  mode_o,
  output logic        active_o,
  output logic        locked_o,
  output logic [1:0]  setpoint_kind_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_SQR, ST_CMP, ST_ROOT, ST_SCALE, ST_DIV, ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;

  logic [15:0] gain_az_q, gain_az_d, gain_el_q, gain_el_d;
  logic [13:0] limit_q, limit_d;
  logic [7:0]  timeout_q, timeout_d;

  logic engaged_q, engaged_d, stop_q, stop_d, lock_q, lock_d, calc_q, calc_d;
  lgpg_pkg::mode_e mode_q, mode_d;
  lgpg_pkg::kind_e kind_q, kind_d;
  logic [7:0]  idle_q, idle_d;
  logic [17:0] velx_q, velx_d, vely_q, vely_d;

  logic        negx_q, negx_d, negy_q, negy_d;
  logic [15:0] absel_q, absel_d, absaz_q, absaz_d;
  logic [31:0] ax_q, ax_d, ay_q, ay_d, sx_q, sx_d, sy_q, sy_d;
  logic [63:0] sum_q, sum_d, res_q, res_d, one_q, one_d;
  logic [19:0] lim_q, lim_d, lsh_q, lsh_d;
  logic [51:0] numx_q, numx_d, numy_q, numy_d, dsh_q, dsh_d;
  logic [16:0] qx_q, qx_d, qy_q, qy_d;

  logic        out_valid_q, out_valid_d;
  logic [17:0] ovx_q, ovx_d, ovy_q, ovy_d;
  logic [1:0]  omode_q, omode_d, okind_q, okind_d;
  logic        oact_q, oact_d, olock_q, olock_d;

  logic        cfg_wr;
  logic [1:0]  ls;
  logic        lock_in, eng_c, sp_c, zero_c, calc_c;
  logic [7:0]  idle_c;
  lgpg_pkg::mode_e mode_c;
  lgpg_pkg::kind_e kind_c;
  logic [13:0] lim_sat;
  logic [39:0] lsq;
  logic [63:0] root_trial;
  logic [35:0] den;
  logic [17:0] vx_fin, vy_fin;

  assign cfg_wr     = psel && penable && pwrite;
  assign pready     = 1'b1;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    unique case (lgpg_pkg::reg_e'(paddr[3:2]))
      lgpg_pkg::REG_GAIN_AZ: prdata = {16'd0, gain_az_q};
      lgpg_pkg::REG_GAIN_EL: prdata = {16'd0, gain_el_q};
      lgpg_pkg::REG_LIMIT:   prdata = {18'd0, limit_q};
      lgpg_pkg::REG_TIMEOUT: prdata = {24'd0, timeout_q};
      default:               prdata = 32'd0;
    endcase
  end

  // period control, evaluated on the accepted word
  always_comb begin
    ls      = status_word_i[10:9];
    lock_in = (ls == 2'b01) || (ls == 2'b10);
    eng_c   = engaged_q;
    sp_c    = stop_q;
    mode_c  = mode_q;
    zero_c  = 1'b0;
    calc_c  = 1'b0;
    if (func_i) begin
      idle_c = 8'd0;
      if (lock_in && !eng_c) begin
        if (vehicle_ready_i && position_valid_i) begin
          eng_c  = 1'b1;
          mode_c = lgpg_pkg::MODE_ACTIVE;
        end
      end else if (!lock_in && eng_c) begin
        eng_c  = 1'b0;
        sp_c   = 1'b0;
        zero_c = 1'b1;
        mode_c = lgpg_pkg::MODE_LOST;
      end
      if (eng_c) begin
        calc_c = 1'b1;
        sp_c   = 1'b1;
      end
    end else begin
      idle_c = (idle_q == 8'hFF) ? idle_q : idle_q + 8'd1;
    end
    if (idle_c >= timeout_q) begin
      if (eng_c) begin
        eng_c  = 1'b0;
        sp_c   = 1'b0;
        zero_c = 1'b1;
        calc_c = 1'b0;
      end
      mode_c = lgpg_pkg::MODE_WAITING;
    end
    if (eng_c) begin
      kind_c = lgpg_pkg::KIND_VELOCITY;
    end else if (sp_c) begin
      kind_c = lgpg_pkg::KIND_STOP;
      sp_c   = 1'b0;
    end else begin
      kind_c = lgpg_pkg::KIND_NONE;
    end
  end

  assign lim_sat    = (limit_q > lgpg_pkg::LimitMaxCms) ? lgpg_pkg::LimitMaxCms : limit_q;
  assign lsq        = lim_q * lim_q;
  assign root_trial = res_q + one_q;
  assign den        = {1'b0, res_q[31:0], 3'b000} + {3'b000, res_q[31:0], 1'b0};
  assign vx_fin     = negx_q ? 18'(-{1'b0, qx_q}) : {1'b0, qx_q};
  assign vy_fin     = negy_q ? 18'(-{1'b0, qy_q}) : {1'b0, qy_q};

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    gain_az_d = gain_az_q;
    gain_el_d = gain_el_q;
    limit_d   = limit_q;
    timeout_d = timeout_q;
    engaged_d = engaged_q;
    stop_d    = stop_q;
    lock_d    = lock_q;
    calc_d    = calc_q;
    mode_d    = mode_q;
    kind_d    = kind_q;
    idle_d    = idle_q;
    velx_d    = velx_q;
    vely_d    = vely_q;
    negx_d    = negx_q;
    negy_d    = negy_q;
    absel_d   = absel_q;
    absaz_d   = absaz_q;
    ax_d      = ax_q;
    ay_d      = ay_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    sum_d     = sum_q;
    res_d     = res_q;
    one_d     = one_q;
    lim_d     = lim_q;
    lsh_d     = lsh_q;
    numx_d    = numx_q;
    numy_d    = numy_q;
    dsh_d     = dsh_q;
    qx_d      = qx_q;
    qy_d      = qy_q;
    out_valid_d = out_valid_q;
    ovx_d     = ovx_q;
    ovy_d     = ovy_q;
    omode_d   = omode_q;
    okind_d   = okind_q;
    oact_d    = oact_q;
    olock_d   = olock_q;

    if (cfg_wr) begin
      unique case (lgpg_pkg::reg_e'(paddr[3:2]))
        lgpg_pkg::REG_GAIN_AZ: gain_az_d = pwdata[15:0];
        lgpg_pkg::REG_GAIN_EL: gain_el_d = pwdata[15:0];
        lgpg_pkg::REG_LIMIT:   limit_d   = pwdata[13:0];
        lgpg_pkg::REG_TIMEOUT: timeout_d = pwdata[7:0];
        default: ;
      endcase
    end

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          engaged_d = eng_c;
          stop_d    = sp_c;
          mode_d    = mode_c;
          kind_d    = kind_c;
          idle_d    = idle_c;
          calc_d    = calc_c;
          if (func_i) lock_d = lock_in;
          if (zero_c) begin
            velx_d = '0;
            vely_d = '0;
          end
          negx_d  = !offset_elevation_i[15] && (offset_elevation_i != 16'sd0);
          negy_d  = !offset_azimuth_i[15] && (offset_azimuth_i != 16'sd0);
          absel_d = offset_elevation_i[15] ? 16'(-offset_elevation_i) : offset_elevation_i;
          absaz_d = offset_azimuth_i[15] ? 16'(-offset_azimuth_i) : offset_azimuth_i;
          ax_d    = '0;
          ay_d    = '0;
          lim_d   = 20'(lim_sat * lgpg_pkg::CmToTenthMm);
          cnt_d   = 5'd15;
          state_d = calc_c ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL: begin
        // offsets times gains, offset bits msb first
        ax_d    = {ax_q[30:0], 1'b0} + (absel_q[15] ? {16'd0, gain_el_q} : 32'd0);
        ay_d    = {ay_q[30:0], 1'b0} + (absaz_q[15] ? {16'd0, gain_az_q} : 32'd0);
        absel_d = {absel_q[14:0], 1'b0};
        absaz_d = {absaz_q[14:0], 1'b0};
        cnt_d   = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          sx_d    = ax_d;
          sy_d    = ay_d;
          sum_d   = '0;
          cnt_d   = 5'd31;
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        sum_d = {sum_q[62:0], 1'b0} + (sx_q[31] ? {32'd0, ax_q} : 64'd0)
              + (sy_q[31] ? {32'd0, ay_q} : 64'd0);
        sx_d  = {sx_q[30:0], 1'b0};
        sy_d  = {sy_q[30:0], 1'b0};
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) state_d = ST_CMP;
      end
      ST_CMP: begin
        if (sum_q > {24'd0, lsq}) begin
          res_d   = '0;
          one_d   = 64'h4000_0000_0000_0000;
          cnt_d   = 5'd31;
          state_d = ST_ROOT;
        end else begin
          // within the cap: plain divide by ten
          numx_d  = {20'd0, ax_q};
          numy_d  = {20'd0, ay_q};
          dsh_d   = {16'd0, 36'd10} << 16;
          qx_d    = '0;
          qy_d    = '0;
          cnt_d   = 5'd16;
          state_d = ST_DIV;
        end
      end
      ST_ROOT: begin
        // bitwise square root of the sum, taking the radicand two bits at a time
        if (sum_q >= root_trial) begin
          sum_d = sum_q - root_trial;
          res_d = (res_q >> 1) + one_q;
        end else begin
          res_d = res_q >> 1;
        end
        one_d = one_q >> 2;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          numx_d  = '0;
          numy_d  = '0;
          lsh_d   = lim_q;
          cnt_d   = 5'd19;
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        numx_d = {numx_q[50:0], 1'b0} + (lsh_q[19] ? {20'd0, ax_q} : 52'd0);
        numy_d = {numy_q[50:0], 1'b0} + (lsh_q[19] ? {20'd0, ay_q} : 52'd0);
        lsh_d  = {lsh_q[18:0], 1'b0};
        cnt_d  = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          dsh_d   = {den, 16'd0};
          qx_d    = '0;
          qy_d    = '0;
          cnt_d   = 5'd16;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // restoring divide, one quotient bit per cycle for both axes
        if (numx_q >= dsh_q) begin
          numx_d = numx_q - dsh_q;
          qx_d   = {qx_q[15:0], 1'b1};
        end else begin
          qx_d   = {qx_q[15:0], 1'b0};
        end
        if (numy_q >= dsh_q) begin
          numy_d = numy_q - dsh_q;
          qy_d   = {qy_q[15:0], 1'b1};
        end else begin
          qy_d   = {qy_q[15:0], 1'b0};
        end
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          if (calc_q) begin
            velx_d = vx_fin;
            vely_d = vy_fin;
            ovx_d  = vx_fin;
            ovy_d  = vy_fin;
          end else begin
            ovx_d  = velx_q;
            ovy_d  = vely_q;
          end
          omode_d     = mode_q;
          okind_d     = kind_q;
          oact_d      = engaged_q;
          olock_d     = lock_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      gain_az_q   <= lgpg_pkg::GainAzReset;
      gain_el_q   <= lgpg_pkg::GainElReset;
      limit_q     <= lgpg_pkg::LimitReset;
      timeout_q   <= lgpg_pkg::TimeoutReset;
      engaged_q   <= 1'b0;
      stop_q      <= 1'b0;
      lock_q      <= 1'b0;
      calc_q      <= 1'b0;
      mode_q      <= lgpg_pkg::MODE_WAITING;
      kind_q      <= lgpg_pkg::KIND_NONE;
      idle_q      <= 8'hFF;
      velx_q      <= '0;
      vely_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      gain_az_q   <= gain_az_d;
      gain_el_q   <= gain_el_d;
      limit_q     <= limit_d;
      timeout_q   <= timeout_d;
      engaged_q   <= engaged_d;
      stop_q      <= stop_d;
      lock_q      <= lock_d;
      calc_q      <= calc_d;
      mode_q      <= mode_d;
      kind_q      <= kind_d;
      idle_q      <= idle_d;
      velx_q      <= velx_d;
      vely_q      <= vely_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    negx_q  <= negx_d;
    negy_q  <= negy_d;
    absel_q <= absel_d;
    absaz_q <= absaz_d;
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    sx_q    <= sx_d;
    sy_q    <= sy_d;
    sum_q   <= sum_d;
    res_q   <= res_d;
    one_q   <= one_d;
    lim_q   <= lim_d;
    lsh_q   <= lsh_d;
    numx_q  <= numx_d;
    numy_q  <= numy_d;
    dsh_q   <= dsh_d;
    qx_q    <= qx_d;
    qy_q    <= qy_d;
    ovx_q   <= ovx_d;
    ovy_q   <= ovy_d;
    omode_q <= omode_d;
    okind_q <= okind_d;
    oact_q  <= oact_d;
    olock_q <= olock_d;
  end

  assign out_valid_o      = out_valid_q;
  assign velocity_x_mms_o = ovx_q;
  assign velocity_y_mms_o = ovy_q;
  assign mode_o           = omode_q;
  assign active_o         = oact_q;
  assign locked_o         = olock_q;
  assign setpoint_kind_o  = okind_q;

`include "lock_gated_proportional_guidance_assert.svh"

  `LGPG_ASSERT_NOW(a_vel_kind_active, out_valid_q && (okind_q == lgpg_pkg::KIND_VELOCITY), oact_q, "velocity word while not engaged")
  `LGPG_ASSERT_NOW(a_idle_zero_vel, out_valid_q && !oact_q, (ovx_q == 18'd0) && (ovy_q == 18'd0), "nonzero velocity while not engaged")
  `LGPG_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "accepted a word while one is in work")

endmodule
